// ===== hdl/beacon_frame_parser_macros.svh =====
// Assertion macros used by the beacon frame parser checker.
`ifndef BEACON_FRAME_PARSER_MACROS_SVH
`define BEACON_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define BFP_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define BFP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/bfp_pkg.sv =====
// Types and constants shared by the beacon frame parser files.
package bfp_pkg;

   localparam int BYTE_W      = 8;
   localparam int VALUE_W     = 64;
   localparam int KIND_W      = 4;
   localparam int STATUS_W    = 2;
   localparam int FLAG_POS_W  = 6;
   localparam int EID_LEN_W   = 11;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;
   localparam int PRESENT_W   = 3;

   typedef enum logic [3:0] {
      PH_VERSION,
      PH_FLAGS,
      PH_SEQ_HI,
      PH_SEQ_LO,
      PH_EID_LEN,
      PH_EID_BYTES,
      PH_SVC_COUNT,
      PH_SVC_NUM,
      PH_SVC_LEN,
      PH_SVC_BYTES,
      PH_PERIOD,
      PH_DONE
   } phase_type;

   localparam logic [KIND_W-1:0] KIND_NONE        = 4'd0;
   localparam logic [KIND_W-1:0] KIND_VERSION     = 4'd1;
   localparam logic [KIND_W-1:0] KIND_FLAGS       = 4'd2;
   localparam logic [KIND_W-1:0] KIND_SEQUENCE    = 4'd3;
   localparam logic [KIND_W-1:0] KIND_EID_LENGTH  = 4'd4;
   localparam logic [KIND_W-1:0] KIND_EID_BYTE    = 4'd5;
   localparam logic [KIND_W-1:0] KIND_SVC_COUNT   = 4'd6;
   localparam logic [KIND_W-1:0] KIND_SVC_NUMBER  = 4'd7;
   localparam logic [KIND_W-1:0] KIND_SVC_LENGTH  = 4'd8;
   localparam logic [KIND_W-1:0] KIND_SVC_BYTE    = 4'd9;
   localparam logic [KIND_W-1:0] KIND_PERIOD      = 4'd10;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_TRUNCATED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SDNV_LONG = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EID_LONG  = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_EID_FLAG_BIT     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SERVICE_FLAG_BIT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PERIOD_FLAG_BIT  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_EID_LENGTH   = 2'd3;

   localparam logic [FLAG_POS_W-1:0] EID_FLAG_BIT_RESET     = 6'd0;
   localparam logic [FLAG_POS_W-1:0] SERVICE_FLAG_BIT_RESET = 6'd1;
   localparam logic [FLAG_POS_W-1:0] PERIOD_FLAG_BIT_RESET  = 6'd3;
   localparam logic [EID_LEN_W-1:0]  MAX_EID_LENGTH_RESET   = 11'd256;

   // Positions in the present mask.
   localparam int PRESENT_EID    = 0;
   localparam int PRESENT_SVC    = 1;
   localparam int PRESENT_PERIOD = 2;

   typedef struct packed {
      logic [BYTE_W-1:0] byte_value;
      logic              last_byte;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0]   field_kind;
      logic [VALUE_W-1:0]  field_value;
      logic [STATUS_W-1:0] parse_status;
      logic                beacon_done;
   } rsp_type;

endpackage

// ===== hdl/beacon_frame_parser.sv =====
// Beacon frame parser: byte-serial decoder for neighbour-discovery beacons.
//
// Bytes enter on the req_ channel (valid/ready), one item per byte, with
// last_byte marking the final byte of the received buffer. Each byte that
// completes a field, or that ends the beacon, yields one item on the rsp_
// channel; other bytes yield nothing. Settings are written through the csr_
// port while the parser is idle; the user must keep to this, as the block
// itself does not enforce it. An accepted byte is held in an input
// register and decoded into the result register once that register is
// empty or its result is being taken. One byte is taken every cycle while
// the receiver keeps rsp_ready high; the rate is set by the single decode
// step between the input and result registers, which carries the SDNV
// accumulator and the field counters. When the receiver holds rsp_ready
// low with a result waiting, the input register can still take one byte,
// after which req_ready stays low until the result is taken; nothing is
// lost. Synchronous reset empties both registers, returns the parser to
// expect a version byte and restores the default settings.
module beacon_frame_parser #(
   parameter int SDNV_BYTES_MAX = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  bfp_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output bfp_pkg::rsp_type                 rsp_data,
   input  logic                             csr_we,
   input  logic [bfp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bfp_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int CNT_W = $clog2(SDNV_BYTES_MAX + 1);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(SDNV_BYTES_MAX);

   // Settings.
   logic [bfp_pkg::FLAG_POS_W-1:0] eid_flag_bit_ff;
   logic [bfp_pkg::FLAG_POS_W-1:0] service_flag_bit_ff;
   logic [bfp_pkg::FLAG_POS_W-1:0] period_flag_bit_ff;
   logic [bfp_pkg::EID_LEN_W-1:0]  max_eid_length_ff;

   // Input and result registers.
   logic             in_valid_ff;
   bfp_pkg::req_type in_data_ff;
   logic             out_valid_ff;
   bfp_pkg::rsp_type out_data_ff;

   // Parser state.
   bfp_pkg::phase_type                phase_ff, phase_in;
   logic [bfp_pkg::VALUE_W-1:0]       acc_ff, acc_in;
   logic [CNT_W-1:0]                  cnt_ff, cnt_in;
   logic [bfp_pkg::PRESENT_W-1:0]     present_ff, present_in;
   logic [bfp_pkg::VALUE_W-1:0]       bytes_left_ff, bytes_left_in;
   logic [bfp_pkg::VALUE_W-1:0]       services_left_ff, services_left_in;
   logic                              finished_ff, finished_in;

   logic advance;
   logic has_result;
   bfp_pkg::rsp_type result;

   logic [bfp_pkg::BYTE_W-1:0]  cur_byte;
   logic                        cur_last;
   logic [CNT_W-1:0]            cnt_inc;
   logic                        acc_full;
   logic [bfp_pkg::VALUE_W-1:0] shifted;
   logic [bfp_pkg::VALUE_W-1:0] bytes_dec;
   logic [bfp_pkg::VALUE_W-1:0] services_dec;
   bfp_pkg::phase_type          ph_after_services;
   bfp_pkg::phase_type          ph_after_eid;
   bfp_pkg::phase_type          ph_after_seq;
   bfp_pkg::phase_type          ph_end_service;
   logic                        sd_long;
   logic                        sd_done;
   logic                        done;
   logic                        restart;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assign cur_byte = in_data_ff.byte_value;
   assign cur_last = in_data_ff.last_byte;

   assign cnt_inc      = cnt_ff + CNT_W'(1);
   assign acc_full     = |acc_ff[bfp_pkg::VALUE_W-1:bfp_pkg::VALUE_W-7];
   assign shifted      = {acc_ff[bfp_pkg::VALUE_W-8:0], cur_byte[6:0]};
   assign bytes_dec    = bytes_left_ff - bfp_pkg::VALUE_W'(1);
   assign services_dec = services_left_ff - bfp_pkg::VALUE_W'(1);

   assign ph_after_services = present_ff[bfp_pkg::PRESENT_PERIOD] ?
                              bfp_pkg::PH_PERIOD : bfp_pkg::PH_DONE;
   assign ph_after_eid      = present_ff[bfp_pkg::PRESENT_SVC] ?
                              bfp_pkg::PH_SVC_COUNT : ph_after_services;
   assign ph_after_seq      = present_ff[bfp_pkg::PRESENT_EID] ?
                              bfp_pkg::PH_EID_LEN : ph_after_eid;
   assign ph_end_service    = (services_dec == '0) ? ph_after_services :
                              bfp_pkg::PH_SVC_NUM;

   always_comb begin
      phase_in         = phase_ff;
      acc_in           = acc_ff;
      cnt_in           = cnt_ff;
      present_in       = present_ff;
      bytes_left_in    = bytes_left_ff;
      services_left_in = services_left_ff;
      finished_in      = finished_ff;
      result.field_kind   = bfp_pkg::KIND_NONE;
      result.field_value  = '0;
      result.parse_status = bfp_pkg::STATUS_OK;
      result.beacon_done  = 1'b0;
      sd_long    = 1'b0;
      sd_done    = 1'b0;
      done       = 1'b0;
      restart    = 1'b0;
      has_result = 1'b0;

      if (finished_ff) begin
         // Bytes after an early end are dropped until the buffer's last byte.
         restart = cur_last;
      end else begin
         case (phase_ff)
            bfp_pkg::PH_VERSION: begin
               result.field_kind  = bfp_pkg::KIND_VERSION;
               result.field_value = bfp_pkg::VALUE_W'(cur_byte);
               phase_in           = bfp_pkg::PH_FLAGS;
            end
            bfp_pkg::PH_FLAGS, bfp_pkg::PH_EID_LEN, bfp_pkg::PH_SVC_COUNT,
            bfp_pkg::PH_SVC_LEN, bfp_pkg::PH_PERIOD: begin
               cnt_in = cnt_inc;
               if (acc_full) begin
                  sd_long = 1'b1;
               end else begin
                  acc_in = shifted;
                  if (cur_byte[7]) begin
                     sd_long = (cnt_inc >= CNT_LIMIT);
                  end else begin
                     sd_done = 1'b1;
                     acc_in  = '0;
                     cnt_in  = '0;
                  end
               end
            end
            bfp_pkg::PH_SEQ_HI: begin
               acc_in   = bfp_pkg::VALUE_W'(cur_byte);
               phase_in = bfp_pkg::PH_SEQ_LO;
            end
            bfp_pkg::PH_SEQ_LO: begin
               result.field_kind  = bfp_pkg::KIND_SEQUENCE;
               result.field_value = bfp_pkg::VALUE_W'({acc_ff[7:0], cur_byte});
               acc_in             = '0;
               phase_in           = ph_after_seq;
            end
            bfp_pkg::PH_EID_BYTES: begin
               result.field_kind  = bfp_pkg::KIND_EID_BYTE;
               result.field_value = bfp_pkg::VALUE_W'(cur_byte);
               bytes_left_in      = bytes_dec;
               phase_in = (bytes_dec == '0) ? ph_after_eid : bfp_pkg::PH_EID_BYTES;
            end
            bfp_pkg::PH_SVC_NUM: begin
               result.field_kind  = bfp_pkg::KIND_SVC_NUMBER;
               result.field_value = bfp_pkg::VALUE_W'(cur_byte);
               phase_in           = bfp_pkg::PH_SVC_LEN;
            end
            bfp_pkg::PH_SVC_BYTES: begin
               result.field_kind  = bfp_pkg::KIND_SVC_BYTE;
               result.field_value = bfp_pkg::VALUE_W'(cur_byte);
               bytes_left_in      = bytes_dec;
               if (bytes_dec == '0) begin
                  services_left_in = services_dec;
                  phase_in         = ph_end_service;
               end
            end
            default: begin
               phase_in = bfp_pkg::PH_DONE;
            end
         endcase

         if (sd_long) begin
            result.parse_status = bfp_pkg::STATUS_SDNV_LONG;
         end else if (sd_done) begin
            result.field_value = shifted;
            case (phase_ff)
               bfp_pkg::PH_FLAGS: begin
                  result.field_kind = bfp_pkg::KIND_FLAGS;
                  present_in[bfp_pkg::PRESENT_EID]    = shifted[eid_flag_bit_ff];
                  present_in[bfp_pkg::PRESENT_SVC]    = shifted[service_flag_bit_ff];
                  present_in[bfp_pkg::PRESENT_PERIOD] = shifted[period_flag_bit_ff];
                  phase_in = bfp_pkg::PH_SEQ_HI;
               end
               bfp_pkg::PH_EID_LEN: begin
                  result.field_kind = bfp_pkg::KIND_EID_LENGTH;
                  if (shifted > bfp_pkg::VALUE_W'(max_eid_length_ff)) begin
                     result.parse_status = bfp_pkg::STATUS_EID_LONG;
                  end else if (shifted == '0) begin
                     phase_in = ph_after_eid;
                  end else begin
                     bytes_left_in = shifted;
                     phase_in      = bfp_pkg::PH_EID_BYTES;
                  end
               end
               bfp_pkg::PH_SVC_COUNT: begin
                  result.field_kind = bfp_pkg::KIND_SVC_COUNT;
                  services_left_in  = shifted;
                  phase_in = (shifted == '0) ? ph_after_services : bfp_pkg::PH_SVC_NUM;
               end
               bfp_pkg::PH_SVC_LEN: begin
                  result.field_kind = bfp_pkg::KIND_SVC_LENGTH;
                  if (shifted == '0) begin
                     services_left_in = services_dec;
                     phase_in         = ph_end_service;
                  end else begin
                     bytes_left_in = shifted;
                     phase_in      = bfp_pkg::PH_SVC_BYTES;
                  end
               end
               default: begin
                  result.field_kind = bfp_pkg::KIND_PERIOD;
                  phase_in          = bfp_pkg::PH_DONE;
               end
            endcase
         end

         // The beacon ends on an error, on its final field, or on the buffer's
         // last byte, in which case an unfinished beacon is truncated.
         done = 1'b1;
         if (result.parse_status == bfp_pkg::STATUS_OK &&
             phase_in != bfp_pkg::PH_DONE) begin
            if (cur_last) begin
               result.parse_status = bfp_pkg::STATUS_TRUNCATED;
            end else begin
               done = 1'b0;
            end
         end
         result.beacon_done = done;
         if (done) begin
            if (cur_last) begin
               restart = 1'b1;
            end else begin
               finished_in = 1'b1;
            end
         end
         has_result = (result.field_kind != bfp_pkg::KIND_NONE) || done;
      end

      if (restart) begin
         phase_in         = bfp_pkg::PH_VERSION;
         acc_in           = '0;
         cnt_in           = '0;
         present_in       = '0;
         bytes_left_in    = '0;
         services_left_in = '0;
         finished_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eid_flag_bit_ff     <= bfp_pkg::EID_FLAG_BIT_RESET;
         service_flag_bit_ff <= bfp_pkg::SERVICE_FLAG_BIT_RESET;
         period_flag_bit_ff  <= bfp_pkg::PERIOD_FLAG_BIT_RESET;
         max_eid_length_ff   <= bfp_pkg::MAX_EID_LENGTH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            bfp_pkg::CSR_EID_FLAG_BIT: begin
               eid_flag_bit_ff <= csr_wdata[bfp_pkg::FLAG_POS_W-1:0];
            end
            bfp_pkg::CSR_SERVICE_FLAG_BIT: begin
               service_flag_bit_ff <= csr_wdata[bfp_pkg::FLAG_POS_W-1:0];
            end
            bfp_pkg::CSR_PERIOD_FLAG_BIT: begin
               period_flag_bit_ff <= csr_wdata[bfp_pkg::FLAG_POS_W-1:0];
            end
            bfp_pkg::CSR_MAX_EID_LENGTH: begin
               max_eid_length_ff <= csr_wdata[bfp_pkg::EID_LEN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && has_result) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && has_result) begin
         out_data_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= bfp_pkg::PH_VERSION;
         acc_ff           <= '0;
         cnt_ff           <= '0;
         present_ff       <= '0;
         bytes_left_ff    <= '0;
         services_left_ff <= '0;
         finished_ff      <= 1'b0;
      end else if (advance) begin
         phase_ff         <= phase_in;
         acc_ff           <= acc_in;
         cnt_ff           <= cnt_in;
         present_ff       <= present_in;
         bytes_left_ff    <= bytes_left_in;
         services_left_ff <= services_left_in;
         finished_ff      <= finished_in;
      end
   end

endmodule

// ===== hdl/bfp_checker.sv =====
// Port-level checker for the beacon frame parser, with its bind statement.
`include "beacon_frame_parser_macros.svh"

module bfp_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input bfp_pkg::rsp_type rsp_data
);

   // A stalled result item keeps its contents.
   `BFP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result item changed while stalled")

   // An item without a field is only sent to close a beacon.
   `BFP_ASSERT_IMP(a_empty_ends, rsp_valid && rsp_data.field_kind == bfp_pkg::KIND_NONE, rsp_data.beacon_done, "empty result item does not end the beacon")

   // Every error status ends the beacon.
   `BFP_ASSERT_IMP(a_error_ends, rsp_valid && rsp_data.parse_status != bfp_pkg::STATUS_OK, rsp_data.beacon_done, "error status without beacon end")

   // An over-long EID is reported on the EID length field itself.
   `BFP_ASSERT_IMP(a_eid_long_kind, rsp_valid && rsp_data.parse_status == bfp_pkg::STATUS_EID_LONG, rsp_data.field_kind == bfp_pkg::KIND_EID_LENGTH, "EID length error on wrong field")

endmodule

bind beacon_frame_parser bfp_checker u_bfp_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== dv/tb_beacon_frame_parser.sv =====
// Self-checking testbench for the beacon frame parser with a built-in byte-level predictor.
module tb_beacon_frame_parser;

   localparam int SDNV_BYTES_MAX = 10;
   localparam int CLOCK_PERIOD   = 10;
   localparam int ITEMS          = 1700;
   localparam int SETTING_PHASES = 6;
   localparam int DRAIN_CYCLES   = 8;
   localparam int QUIET_LIMIT    = 2000;

   // Tracks the parser's state byte by byte and holds the results still owed by the block.
   class beacon_scoreboard;
      typedef enum {SDNV_MORE, SDNV_DONE, SDNV_LONG} sdnv_step_type;

      logic [bfp_pkg::FLAG_POS_W-1:0] eid_pos;
      logic [bfp_pkg::FLAG_POS_W-1:0] svc_pos;
      logic [bfp_pkg::FLAG_POS_W-1:0] period_pos;
      logic [bfp_pkg::EID_LEN_W-1:0]  eid_limit;
      bfp_pkg::phase_type             cur_phase;
      logic [bfp_pkg::VALUE_W-1:0]    acc;
      int unsigned                    sdnv_len;
      logic [bfp_pkg::PRESENT_W-1:0]  present;
      logic [bfp_pkg::VALUE_W-1:0]    bytes_left;
      logic [bfp_pkg::VALUE_W-1:0]    services_left;
      bit                             finished;
      bfp_pkg::rsp_type               expected[$];
      int unsigned                    mismatches;
      int unsigned                    results_seen;

      function new();
         eid_pos = bfp_pkg::EID_FLAG_BIT_RESET;
         svc_pos = bfp_pkg::SERVICE_FLAG_BIT_RESET;
         period_pos = bfp_pkg::PERIOD_FLAG_BIT_RESET;
         eid_limit = bfp_pkg::MAX_EID_LENGTH_RESET;
         mismatches = 0;
         results_seen = 0;
         start_beacon();
      endfunction

      function void start_beacon();
         cur_phase = bfp_pkg::PH_VERSION;
         acc = '0;
         sdnv_len = 0;
         present = '0;
         bytes_left = '0;
         services_left = '0;
         finished = 1'b0;
      endfunction

      function void write_reg(input logic [bfp_pkg::CSR_INDEX_W-1:0] idx,
                              input logic [bfp_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            bfp_pkg::CSR_EID_FLAG_BIT:     eid_pos = data[bfp_pkg::FLAG_POS_W-1:0];
            bfp_pkg::CSR_SERVICE_FLAG_BIT: svc_pos = data[bfp_pkg::FLAG_POS_W-1:0];
            bfp_pkg::CSR_PERIOD_FLAG_BIT:  period_pos = data[bfp_pkg::FLAG_POS_W-1:0];
            bfp_pkg::CSR_MAX_EID_LENGTH:   eid_limit = data[bfp_pkg::EID_LEN_W-1:0];
            default: ;
         endcase
      endfunction

      function bfp_pkg::phase_type after_services();
         return present[bfp_pkg::PRESENT_PERIOD] ? bfp_pkg::PH_PERIOD : bfp_pkg::PH_DONE;
      endfunction

      function bfp_pkg::phase_type after_eid();
         return present[bfp_pkg::PRESENT_SVC] ? bfp_pkg::PH_SVC_COUNT : after_services();
      endfunction

      function bfp_pkg::phase_type after_sequence();
         return present[bfp_pkg::PRESENT_EID] ? bfp_pkg::PH_EID_LEN : after_eid();
      endfunction

      function bfp_pkg::phase_type end_of_service();
         services_left = services_left - 1;
         return (services_left == 0) ? after_services() : bfp_pkg::PH_SVC_NUM;
      endfunction

      // The overflow test looks at the accumulator before the shift, so a value
      // needing more than 64 bits is caught on the byte that would push it out.
      function sdnv_step_type sdnv_step(input logic [bfp_pkg::BYTE_W-1:0] b,
                                        output logic [bfp_pkg::VALUE_W-1:0] v);
         v = '0;
         sdnv_len++;
         if (acc[63:57] != 0) return SDNV_LONG;
         acc = {acc[56:0], b[6:0]};
         if (b[7]) return (sdnv_len >= SDNV_BYTES_MAX) ? SDNV_LONG : SDNV_MORE;
         v = acc;
         acc = '0;
         sdnv_len = 0;
         return SDNV_DONE;
      endfunction

      // Returns 1 when the byte was parsed, 0 when it was skipped after a finished beacon.
      function bit note_byte(input bfp_pkg::req_type item);
         logic [bfp_pkg::BYTE_W-1:0]   b;
         logic                         is_last;
         logic [bfp_pkg::KIND_W-1:0]   kind;
         logic [bfp_pkg::VALUE_W-1:0]  val;
         logic [bfp_pkg::VALUE_W-1:0]  v;
         logic [bfp_pkg::STATUS_W-1:0] status;
         bfp_pkg::phase_type           nxt;
         bit                           in_sdnv;
         bit                           done;
         sdnv_step_type                r;
         bfp_pkg::rsp_type             want;
         b = item.byte_value;
         is_last = item.last_byte;
         kind = bfp_pkg::KIND_NONE;
         val = '0;
         v = '0;
         status = bfp_pkg::STATUS_OK;
         nxt = cur_phase;
         in_sdnv = 1'b0;
         r = SDNV_MORE;
         if (finished) begin
            if (is_last) start_beacon();
            return 1'b0;
         end
         case (cur_phase)
            bfp_pkg::PH_VERSION: begin
               kind = bfp_pkg::KIND_VERSION;
               val = 64'(b);
               nxt = bfp_pkg::PH_FLAGS;
            end
            bfp_pkg::PH_FLAGS, bfp_pkg::PH_EID_LEN, bfp_pkg::PH_SVC_COUNT,
            bfp_pkg::PH_SVC_LEN, bfp_pkg::PH_PERIOD: begin
               in_sdnv = 1'b1;
               r = sdnv_step(b, v);
            end
            bfp_pkg::PH_SEQ_HI: begin
               acc = 64'(b);
               nxt = bfp_pkg::PH_SEQ_LO;
            end
            bfp_pkg::PH_SEQ_LO: begin
               kind = bfp_pkg::KIND_SEQUENCE;
               val = {48'd0, acc[7:0], b};
               acc = '0;
               nxt = after_sequence();
            end
            bfp_pkg::PH_EID_BYTES: begin
               kind = bfp_pkg::KIND_EID_BYTE;
               val = 64'(b);
               bytes_left = bytes_left - 1;
               nxt = (bytes_left == 0) ? after_eid() : bfp_pkg::PH_EID_BYTES;
            end
            bfp_pkg::PH_SVC_NUM: begin
               kind = bfp_pkg::KIND_SVC_NUMBER;
               val = 64'(b);
               nxt = bfp_pkg::PH_SVC_LEN;
            end
            bfp_pkg::PH_SVC_BYTES: begin
               kind = bfp_pkg::KIND_SVC_BYTE;
               val = 64'(b);
               bytes_left = bytes_left - 1;
               nxt = (bytes_left == 0) ? end_of_service() : bfp_pkg::PH_SVC_BYTES;
            end
            default: nxt = bfp_pkg::PH_DONE;
         endcase

         if (in_sdnv && r == SDNV_LONG) begin
            status = bfp_pkg::STATUS_SDNV_LONG;
         end else if (in_sdnv && r == SDNV_DONE) begin
            val = v;
            case (cur_phase)
               bfp_pkg::PH_FLAGS: begin
                  kind = bfp_pkg::KIND_FLAGS;
                  present = {v[period_pos], v[svc_pos], v[eid_pos]};
                  nxt = bfp_pkg::PH_SEQ_HI;
               end
               bfp_pkg::PH_EID_LEN: begin
                  kind = bfp_pkg::KIND_EID_LENGTH;
                  if (v > eid_limit) begin
                     status = bfp_pkg::STATUS_EID_LONG;
                  end else if (v == 0) begin
                     nxt = after_eid();
                  end else begin
                     bytes_left = v;
                     nxt = bfp_pkg::PH_EID_BYTES;
                  end
               end
               bfp_pkg::PH_SVC_COUNT: begin
                  kind = bfp_pkg::KIND_SVC_COUNT;
                  services_left = v;
                  nxt = (v == 0) ? after_services() : bfp_pkg::PH_SVC_NUM;
               end
               bfp_pkg::PH_SVC_LEN: begin
                  kind = bfp_pkg::KIND_SVC_LENGTH;
                  if (v == 0) begin
                     nxt = end_of_service();
                  end else begin
                     bytes_left = v;
                     nxt = bfp_pkg::PH_SVC_BYTES;
                  end
               end
               default: begin
                  kind = bfp_pkg::KIND_PERIOD;
                  nxt = bfp_pkg::PH_DONE;
               end
            endcase
         end
         cur_phase = nxt;

         done = 1'b1;
         if (status == bfp_pkg::STATUS_OK && cur_phase != bfp_pkg::PH_DONE) begin
            if (is_last) status = bfp_pkg::STATUS_TRUNCATED;
            else done = 1'b0;
         end
         if (done) begin
            if (is_last) start_beacon();
            else finished = 1'b1;
         end

         if (kind != bfp_pkg::KIND_NONE || done) begin
            want.field_kind = kind;
            want.field_value = val;
            want.parse_status = status;
            want.beacon_done = done;
            expected.push_back(want);
         end
         return 1'b1;
      endfunction

      task report(input string msg);
         if (mismatches < 40) $display("MISMATCH at result %0d: %s", results_seen, msg);
         mismatches++;
      endtask

      task check_result(input bfp_pkg::rsp_type got);
         bfp_pkg::rsp_type want;
         results_seen++;
         if (expected.size() == 0) begin
            report($sformatf("result kind %0d value %0h arrived with none expected",
                             got.field_kind, got.field_value));
            return;
         end
         want = expected.pop_front();
         if (got.field_kind !== want.field_kind)
            report($sformatf("field_kind got %0d, expected %0d",
                             got.field_kind, want.field_kind));
         if (got.field_value !== want.field_value)
            report($sformatf("field_value got %0h, expected %0h",
                             got.field_value, want.field_value));
         if (got.parse_status !== want.parse_status)
            report($sformatf("parse_status got %0d, expected %0d",
                             got.parse_status, want.parse_status));
         if (got.beacon_done !== want.beacon_done)
            report($sformatf("beacon_done got %0b, expected %0b",
                             got.beacon_done, want.beacon_done));
      endtask

      function int outstanding();
         return expected.size();
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   bfp_pkg::req_type                req_data = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   bfp_pkg::rsp_type                rsp_data;
   logic                            csr_we = 1'b0;
   logic [bfp_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [bfp_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   beacon_scoreboard sb = new();

   bfp_pkg::req_type frame[$];
   int      bytes_parsed = 0;
   int      frames_sent = 0;
   int      settings_applied = 0;
   int      stall_left = 0;
   int      quiet_cycles = 0;
   bit      send_calm = 1'b0;
   bit      recv_calm = 1'b0;

   beacon_frame_parser #(.SDNV_BYTES_MAX(SDNV_BYTES_MAX)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic int draw_wait(input bit calm);
      if (calm) return 0;
      return $urandom_range(0, 19);
   endfunction

   // Accepted bytes feed the predictor; accepted results are checked, after which the
   // receiver may hold off for a while.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (sb.note_byte(req_data)) bytes_parsed++;
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_result(rsp_data);
            if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
            stall_left = draw_wait(recv_calm);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_ready <= (stall_left == 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("Timed out after %0d cycles without an accepted item.", QUIET_LIMIT);
         $display("beacon_frame_parser verification failed");
         $finish;
      end
   end

   task automatic send_byte(input bfp_pkg::req_type item);
      int gap;
      gap = draw_wait(send_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_frame();
      foreach (frame[i]) send_byte(frame[i]);
      frames_sent++;
   endtask

   // Holds the sender off until every owed result has come back and the pipeline is empty.
   task automatic quiesce();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [bfp_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [bfp_pkg::CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   // Upper bits of the flag position words are filled at random; only six bits count.
   task automatic apply_settings(input logic [bfp_pkg::FLAG_POS_W-1:0] eid_pos,
                                 input logic [bfp_pkg::FLAG_POS_W-1:0] svc_pos,
                                 input logic [bfp_pkg::FLAG_POS_W-1:0] per_pos,
                                 input logic [bfp_pkg::EID_LEN_W-1:0] limit);
      logic [4:0] spare;
      spare = 5'($urandom);
      write_reg(bfp_pkg::CSR_EID_FLAG_BIT, {spare, eid_pos});
      spare = 5'($urandom);
      write_reg(bfp_pkg::CSR_SERVICE_FLAG_BIT, {spare, svc_pos});
      spare = 5'($urandom);
      write_reg(bfp_pkg::CSR_PERIOD_FLAG_BIT, {spare, per_pos});
      write_reg(bfp_pkg::CSR_MAX_EID_LENGTH, limit);
      csr_we <= 1'b0;
      settings_applied++;
   endtask

   function automatic void put_byte(input logic [bfp_pkg::BYTE_W-1:0] b,
                                    input logic is_last = 1'b0);
      bfp_pkg::req_type item;
      item.byte_value = b;
      item.last_byte = is_last;
      frame.push_back(item);
   endfunction

   function automatic void close_frame();
      bfp_pkg::req_type item;
      item = frame[frame.size() - 1];
      item.last_byte = 1'b1;
      frame[frame.size() - 1] = item;
   endfunction

   // Big-endian groups of seven bits; at most one leading zero group pads the encoding out.
   function automatic void put_sdnv(input logic [bfp_pkg::VALUE_W-1:0] v);
      int                          groups;
      int                          pad;
      logic [bfp_pkg::VALUE_W-1:0] part;
      groups = 1;
      while (groups < 10 && (v >> (7 * groups)) != 0) groups++;
      pad = (groups < SDNV_BYTES_MAX && $urandom_range(0, 7) == 0) ? 1 : 0;
      repeat (pad) put_byte(8'h80);
      for (int i = groups - 1; i >= 0; i--) begin
         part = v >> (7 * i);
         put_byte({i != 0, part[6:0]});
      end
   endfunction

   function automatic void build_beacon();
      logic [bfp_pkg::VALUE_W-1:0] flags;
      logic [bfp_pkg::VALUE_W-1:0] count;
      logic [bfp_pkg::VALUE_W-1:0] len;
      int                          r;
      int                          n;
      frame.delete();
      put_byte(8'($urandom));
      flags = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'($urandom_range(0, 255));
      flags[sb.eid_pos] = ($urandom_range(0, 2) != 0);
      flags[sb.svc_pos] = ($urandom_range(0, 2) != 0);
      flags[sb.period_pos] = ($urandom_range(0, 2) != 0);
      put_sdnv(flags);
      put_byte(8'($urandom));
      put_byte(8'($urandom));
      if (flags[sb.eid_pos]) begin
         r = $urandom_range(0, 59);
         if (r == 0) len = 64'(sb.eid_limit);
         else if (r == 1) len = 64'(sb.eid_limit) + $urandom_range(1, 4);
         else if (r < 6) len = '0;
         else len = $urandom_range(1, (sb.eid_limit < 6) ? sb.eid_limit : 6);
         put_sdnv(len);
         if (len <= sb.eid_limit) begin
            for (int i = 0; i < len; i++) put_byte(8'($urandom));
         end
      end
      if (flags[sb.svc_pos]) begin
         r = $urandom_range(0, 39);
         if (r == 0) count = {$urandom, $urandom};
         else if (r < 4) count = '0;
         else count = $urandom_range(1, 3);
         put_sdnv(count);
         n = (count > 3) ? 3 : int'(count);
         for (int i = 0; i < n; i++) begin
            put_byte(8'($urandom));
            len = ($urandom_range(0, 29) == 0) ? 64'd20 : 64'($urandom_range(0, 4));
            put_sdnv(len);
            for (int j = 0; j < len; j++) put_byte(8'($urandom));
         end
      end
      if (flags[sb.period_pos])
         put_sdnv($urandom_range(0, 1) ? {$urandom, $urandom} : 64'($urandom_range(0, 1000)));
   endfunction

   // Truncates, pads past the end or corrupts a well-formed beacon now and then.
   function automatic void shape_frame();
      int               r;
      int               k;
      bfp_pkg::req_type item;
      r = $urandom_range(0, 99);
      if (r < 10 && frame.size() > 1) begin
         k = $urandom_range(0, frame.size() - 2);
         frame = frame[0:k];
      end else if (r < 16) begin
         repeat ($urandom_range(1, 3)) put_byte(8'($urandom));
      end else if (r < 22) begin
         k = $urandom_range(0, frame.size() - 1);
         item = frame[k];
         item.byte_value = 8'($urandom);
         frame[k] = item;
      end
      close_frame();
   endfunction

   // A flags SDNV that either never stops within the byte limit or overflows 64 bits.
   function automatic void build_long_sdnv();
      frame.delete();
      put_byte(8'($urandom));
      if ($urandom_range(0, 1)) begin
         repeat (SDNV_BYTES_MAX) put_byte(8'h80 | 8'($urandom));
      end else begin
         put_byte(8'($urandom_range(8'h82, 8'hFF)));
         repeat (SDNV_BYTES_MAX - 2) put_byte(8'h80 | 8'($urandom));
         put_byte(8'($urandom_range(0, 8'h7F)));
      end
      repeat ($urandom_range(0, 2)) put_byte(8'($urandom));
      close_frame();
   endfunction

   function automatic void build_noise();
      frame.delete();
      repeat ($urandom_range(1, 16)) put_byte(8'($urandom), $urandom_range(0, 7) == 0);
      close_frame();
   endfunction

   task automatic run_directed();
      logic [bfp_pkg::BYTE_W-1:0] full_beacon[12];
      full_beacon = '{8'hFF, 8'h03, 8'hFF, 8'h00, 8'h01, 8'h00, 8'h02, 8'h80, 8'h00,
                      8'h01, 8'h01, 8'hAA};
      // Full beacon with a zero-length service; the last service byte closes the buffer.
      frame.delete();
      foreach (full_beacon[i]) put_byte(full_beacon[i]);
      close_frame();
      send_frame();
      // Complete after the sequence number; the trailing byte is skipped.
      frame.delete();
      put_byte(8'h00);
      put_byte(8'h00);
      put_byte(8'h00);
      put_byte(8'h01);
      put_byte(8'h55, 1'b1);
      send_frame();
      // A buffer holding only the version byte is truncated.
      frame.delete();
      put_byte(8'h01, 1'b1);
      send_frame();
      // EID length of 257 is one beyond the default limit.
      frame.delete();
      put_byte(8'h00);
      put_byte(8'h01);
      put_byte(8'h12);
      put_byte(8'h34);
      put_byte(8'h82);
      put_byte(8'h01, 1'b1);
      send_frame();
      // Flags SDNV still continuing on its tenth byte.
      frame.delete();
      put_byte(8'h00);
      repeat (SDNV_BYTES_MAX) put_byte(8'h80);
      close_frame();
      send_frame();
   endtask

   initial begin
      int target;
      int r;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      quiesce();
      for (int p = 0; p < SETTING_PHASES; p++) begin
         case (p)
            0: apply_settings(6'd63, 6'd62, 6'd61, 11'd1024);
            1: apply_settings(6'd0, 6'd0, 6'd0, 11'd1);
            default:
               apply_settings(6'($urandom), 6'($urandom), 6'($urandom),
                              ($urandom_range(0, 3) == 0) ? 11'($urandom_range(1, 1024))
                                                          : 11'($urandom_range(1, 40)));
         endcase
         target = bytes_parsed + ITEMS / SETTING_PHASES;
         while (bytes_parsed < target) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
               build_long_sdnv();
            end else if (r < 16) begin
               build_noise();
            end else begin
               build_beacon();
               shape_frame();
            end
            send_frame();
            if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
            if ($urandom_range(0, 39) == 0) quiesce();
         end
         quiesce();
      end
      $display("Parsed %0d bytes in %0d frames under %0d register settings,",
               bytes_parsed, frames_sent, settings_applied + 1);
      $display("checking %0d results against the predictor.", sb.results_seen);
      if (sb.mismatches == 0 && sb.outstanding() == 0)
         $display("beacon_frame_parser verification clean");
      else
         $display("beacon_frame_parser verification failed");
      $finish;
   end
endmodule
